>>> hdl/bcss_pkg.sv
// ----------------------------------------------------------------------------
// bcss_pkg
// Shared types and codes of the bad-character substring search block.
// ----------------------------------------------------------------------------
package bcss_pkg;

  // Item kinds on the input channel.
  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT    = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  localparam int unsigned POSITION_W = 12;

  typedef enum logic [2:0] {
    S_PATTERN,
    S_TEXT,
    S_DECIDE,
    S_FETCH,
    S_CMP,
    S_STEP,
    S_SHIFT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       pat_wr;       // store a pattern byte
    logic       txt_wr;       // store a text byte
    logic       init_search;  // s = 0, j = m - 1, limit = n - m
    logic       dec_j;        // step to the next pattern byte leftward
    logic       calc_step;    // register the bad-character shift
    logic       apply_step;   // advance s, restart j
    logic       emit;         // present a result and clear for a new pattern
    logic [1:0] code;         // status of the emitted result
    logic       use_s;        // position comes from s
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ovf;          // a store overflowed during this pattern and text
    logic pat_empty;    // no pattern bytes
    logic pat_longer;   // pattern longer than text
    logic byte_eq;      // fetched pattern and text bytes match
    logic j_zero;       // compare index at the leftmost pattern byte
    logic fits;         // advanced alignment still inside the text
  } dp_sts_t;

endpackage

>>> hdl/bcss_ctrl.sv
// ----------------------------------------------------------------------------
// bcss_ctrl
// Controller: load phases, search sequencing and result emission.
// ----------------------------------------------------------------------------
module bcss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             kind,
  input  logic             has_byte,
  input  logic             last,
  input  bcss_pkg::dp_sts_t sts,
  output bcss_pkg::dp_cmd_t cmd,
  output logic             busy
);
  import bcss_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PATTERN;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_PATTERN) && (state != S_TEXT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_PATTERN: begin
        // Items of the wrong kind are dropped, last flag included.
        if (start && (kind == KIND_PATTERN)) begin
          cmd.pat_wr = has_byte;
          if (last) begin
            state_next = S_TEXT;
          end
        end
      end
      S_TEXT: begin
        if (start && (kind == KIND_TEXT)) begin
          cmd.txt_wr = has_byte;
          if (last) begin
            state_next = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (sts.ovf) begin
          cmd.emit   = 1'b1;
          cmd.code   = STATUS_OVERFLOW;
          state_next = S_PATTERN;
        end else if (sts.pat_empty) begin
          cmd.emit   = 1'b1;
          cmd.code   = STATUS_FOUND;
          state_next = S_PATTERN;
        end else if (sts.pat_longer) begin
          cmd.emit   = 1'b1;
          cmd.code   = STATUS_NOT_FOUND;
          state_next = S_PATTERN;
        end else begin
          cmd.init_search = 1'b1;
          state_next      = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (sts.byte_eq) begin
          if (sts.j_zero) begin
            cmd.emit   = 1'b1;
            cmd.code   = STATUS_FOUND;
            cmd.use_s  = 1'b1;
            state_next = S_PATTERN;
          end else begin
            cmd.dec_j  = 1'b1;
            state_next = S_FETCH;
          end
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.calc_step = 1'b1;
        state_next    = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.fits) begin
          cmd.apply_step = 1'b1;
          state_next     = S_FETCH;
        end else begin
          cmd.emit   = 1'b1;
          cmd.code   = STATUS_NOT_FOUND;
          state_next = S_PATTERN;
        end
      end
      default: begin
        state_next = S_PATTERN;
      end
    endcase
  end

endmodule

>>> hdl/bcss_dp.sv
// ----------------------------------------------------------------------------
// bcss_dp
// Datapath: pattern, text and last-occurrence stores, search registers and
// the result register.
// ----------------------------------------------------------------------------
module bcss_dp #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned TEXT_MAX    = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        byte_value,
  input  bcss_pkg::dp_cmd_t cmd,
  output bcss_pkg::dp_sts_t sts,
  output logic              done,
  output logic [1:0]        status,
  output logic [11:0]       position
);
  import bcss_pkg::*;

  localparam int unsigned PIW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned TIW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int unsigned PCW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned TCW = $clog2(TEXT_MAX + 1);
  localparam int unsigned WW  = (TCW > PCW) ? TCW : PCW;

  logic [7:0]     pat_mem [PATTERN_MAX];
  logic [7:0]     txt_mem [TEXT_MAX];
  logic [PIW-1:0] lo_mem  [256];
  logic [255:0]   lo_valid_bits;

  logic [PCW-1:0] pcount;
  logic [TCW-1:0] tcount;
  logic           ovf;

  logic [TCW-1:0] s;
  logic [PIW-1:0] j;
  logic [TCW-1:0] limit;
  logic [PCW-1:0] step;

  logic [7:0]     pdata;
  logic [7:0]     tdata;
  logic [PIW-1:0] lo_data;
  logic           lo_valid;

  logic           pat_full;
  logic           txt_full;
  logic [WW:0]    s_sum;
  logic [TCW-1:0] taddr_sum;
  logic [PCW-1:0] step_calc;
  logic [TCW+POSITION_W-1:0] s_ext;

  assign pat_full = (pcount == PCW'(PATTERN_MAX));
  assign txt_full = (tcount == TCW'(TEXT_MAX));

  // Pattern store, written during the pattern load, read at j.
  always_ff @(posedge clk) begin
    if (cmd.pat_wr && !pat_full) begin
      pat_mem[pcount[PIW-1:0]] <= byte_value;
    end
    pdata <= pat_mem[j];
  end

  // Text store, read at s + j; that sum stays below the text length.
  assign taddr_sum = s + TCW'(j);

  always_ff @(posedge clk) begin
    if (cmd.txt_wr && !txt_full) begin
      txt_mem[tcount[TIW-1:0]] <= byte_value;
    end
    tdata <= txt_mem[taddr_sum[TIW-1:0]];
  end

  // Last-occurrence table; an entry without its valid bit reads as minus one.
  always_ff @(posedge clk) begin
    if (cmd.pat_wr && !pat_full) begin
      lo_mem[byte_value] <= pcount[PIW-1:0];
    end
    lo_data <= lo_mem[tdata];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      lo_valid_bits <= '0;
      lo_valid      <= 1'b0;
    end else begin
      if (cmd.pat_wr && !pat_full) begin
        lo_valid_bits[byte_value] <= 1'b1;
      end
      lo_valid <= lo_valid_bits[tdata];
    end
  end

  // Fill counts and the overflow flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      pcount <= '0;
      tcount <= '0;
      ovf    <= 1'b0;
    end else begin
      if (cmd.pat_wr) begin
        if (pat_full) begin
          ovf <= 1'b1;
        end else begin
          pcount <= pcount + 1'b1;
        end
      end
      if (cmd.txt_wr) begin
        if (txt_full) begin
          ovf <= 1'b1;
        end else begin
          tcount <= tcount + 1'b1;
        end
      end
    end
  end

  // Bad-character shift: past the mismatch when the byte is absent from the
  // pattern, otherwise line up its last occurrence, and never less than one.
  always_comb begin
    if (!lo_valid) begin
      step_calc = PCW'(j) + 1'b1;
    end else if (lo_data < j) begin
      step_calc = PCW'(j - lo_data);
    end else begin
      step_calc = PCW'(1);
    end
  end

  assign s_sum = (WW + 1)'(s) + (WW + 1)'(step);

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      s     <= '0;
      j     <= PIW'(pcount - 1'b1);
      limit <= TCW'(WW'(tcount) - WW'(pcount));
    end
    if (cmd.dec_j) begin
      j <= j - 1'b1;
    end
    if (cmd.calc_step) begin
      step <= step_calc;
    end
    if (cmd.apply_step) begin
      s <= s_sum[TCW-1:0];
      j <= PIW'(pcount - 1'b1);
    end
  end

  assign sts.ovf        = ovf;
  assign sts.pat_empty  = (pcount == '0);
  assign sts.pat_longer = (WW'(pcount) > WW'(tcount));
  assign sts.byte_eq    = (pdata == tdata);
  assign sts.j_zero     = (j == '0);
  assign sts.fits       = (s_sum <= (WW + 1)'(limit));

  // Result register: the offset is reported modulo 4096.
  assign s_ext = (TCW + POSITION_W)'(s);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status   <= cmd.code;
      position <= cmd.use_s ? s_ext[POSITION_W-1:0] : '0;
    end
  end

endmodule

>>> hdl/bad_character_substring_search.sv
// ----------------------------------------------------------------------------
// bad_character_substring_search
// Boyer-Moore bad-character substring search over a loaded pattern and text.
// ----------------------------------------------------------------------------
// Send pattern bytes (kind 0), then text bytes (kind 1), each run closed by an
// item with last set; an item whose kind does not match the current run is
// ignored. Busy stays low while loading. After the item that closes the text,
// busy is high during the search: a decide step handles the trivial cases,
// each byte comparison is a registered read of the pattern and text stores
// followed by a compare, and each mismatch adds a last-occurrence lookup and
// a shift step. The single result is shown for exactly one cycle with done
// high; the receiver cannot stall it, so it must sample status and position
// then. By that cycle the block is already back to loading a new pattern.
module bad_character_substring_search #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned TEXT_MAX    = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic        has_byte,
  input  logic [7:0]  byte_value,
  input  logic        last,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] position
);
  import bcss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bcss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .has_byte (has_byte),
    .last     (last),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  bcss_dp #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .byte_value (byte_value),
    .cmd        (cmd),
    .sts        (sts),
    .done       (done),
    .status     (status),
    .position   (position)
  );

endmodule

>>> hdl/bcss_check.sv
// ----------------------------------------------------------------------------
// bcss_check
// Port-level checks of the search block, bound to its top level.
// ----------------------------------------------------------------------------
module bcss_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        kind,
  input logic        last,
  input logic        done,
  input logic [1:0]  status,
  input logic [11:0] position
);
  import bcss_pkg::*;

  // A search only begins with an accepted item that closes the text.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && kind && last))
    else $error("busy rose without a closing text item");

  // The result appears as the block returns to loading.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while the search is still running");

  // One result per search: never in two consecutive cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_FOUND || status == STATUS_NOT_FOUND ||
              status == STATUS_OVERFLOW))
    else $error("invalid status code");

  a_position_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_FOUND) |-> (position == '0))
    else $error("nonzero position without a match");

endmodule

bind bad_character_substring_search bcss_check u_bcss_check (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .kind     (kind),
  .last     (last),
  .done     (done),
  .status   (status),
  .position (position)
);
